// ===== rtl/sibd_pkg.sv =====
package sibd_pkg;

    localparam int ALPHA_SLOTS = 32;
    localparam int SYM_BITS    = 8;
    localparam int DIGIT_BITS  = 5;
    localparam int BASE_BITS   = 6;
    localparam int ALPHA_BITS  = ALPHA_SLOTS * SYM_BITS;
    localparam int MAX_BASE    = 32;

    // bits of the magnitude consumed per divider cycle
    localparam int DIV_STEP = 8;

    // depth of the queue between front and back, and of the result queue
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SYM_BITS-1:0] SYM_MIN   = 8'd32;
    localparam logic [SYM_BITS-1:0] SYM_MAX   = 8'd126;
    localparam logic [SYM_BITS-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_BITS-1:0] SYM_PLUS  = 8'h2B;

    typedef enum logic [2:0] {
        REG_BASE_SIZE = 3'd0,
        REG_ALPHA_0   = 3'd1,
        REG_ALPHA_1   = 3'd2,
        REG_ALPHA_2   = 3'd3,
        REG_ALPHA_3   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [BASE_BITS-1:0]  base_size;
        logic [ALPHA_BITS-1:0] alphabet;
    } cfg_t;

endpackage

// ===== rtl/sibd_fifo.sv =====
module sibd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/sibd_front.sv =====
module sibd_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sibd_pkg::cfg_t         cfg,
    input  logic                   push,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   full,
    output logic                   q_push,
    output logic [VALUE_WIDTH-1:0] q_data,
    input  logic                   q_full
);

    localparam int IW = $clog2(sibd_pkg::ALPHA_SLOTS);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_CHECK = 3'b010,
        F_PUSH  = 3'b100
    } front_state_t;

    front_state_t                   state_reg, state_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0]         value_reg;
    logic                           accept;
    logic                           base_bad;
    logic                           dup;
    logic                           sym_bad;
    logic [sibd_pkg::SYM_BITS-1:0]  sym;
    logic [sibd_pkg::BASE_BITS-1:0] n;

    assign n      = cfg.base_size;
    assign full   = (state_reg != F_IDLE);
    assign accept = push && (state_reg == F_IDLE);
    assign q_data = value_reg;
    assign sym    = cfg.alphabet[{idx_reg, 3'b000} +: sibd_pkg::SYM_BITS];

    assign base_bad = (n < sibd_pkg::BASE_BITS'(2))
                   || (n > sibd_pkg::BASE_BITS'(sibd_pkg::MAX_BASE))
                   || (n > sibd_pkg::BASE_BITS'(sibd_pkg::ALPHA_SLOTS));

    // compare the symbol under test with every symbol of lower index
    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < sibd_pkg::ALPHA_SLOTS; j++)
        begin
            if ((IW'(j) < idx_reg)
                && (cfg.alphabet[j*sibd_pkg::SYM_BITS +: sibd_pkg::SYM_BITS] == sym))
            begin
                dup = 1'b1;
            end
        end
    end

    assign sym_bad = (sym < sibd_pkg::SYM_MIN) || (sym > sibd_pkg::SYM_MAX)
                  || (sym == sibd_pkg::SYM_MINUS) || (sym == sibd_pkg::SYM_PLUS) || dup;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                idx_next = '0;
                if (accept && !base_bad)
                begin
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                if (sym_bad)
                begin
                    // invalid alphabet: the item is dropped
                    state_next = F_IDLE;
                end
                else if ({1'b0, idx_reg} == n - sibd_pkg::BASE_BITS'(1))
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end
    end

endmodule

// ===== rtl/sibd_back.sv =====
module sibd_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sibd_pkg::cfg_t                  cfg,
    input  logic                            q_empty,
    input  logic [VALUE_WIDTH-1:0]          q_data,
    output logic                            q_pop,
    input  logic                            out_full,
    output logic                            out_push,
    output logic [sibd_pkg::SYM_BITS:0]     out_data
);

    localparam int STEP   = sibd_pkg::DIV_STEP;
    localparam int CHUNKS = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PADW   = CHUNKS * STEP;
    localparam int KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNTW   = $clog2(VALUE_WIDTH + 1);
    localparam int AW     = $clog2(VALUE_WIDTH);
    localparam int BW     = sibd_pkg::BASE_BITS;
    localparam int DW     = sibd_pkg::DIGIT_BITS;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_DIV  = 5'b00010,
        B_SIGN = 5'b00100,
        B_EMIT = 5'b01000,
        B_OUT  = 5'b10000
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [KW-1:0]          chunk_reg, chunk_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   last_reg, last_next;
    logic [PADW-1:0]        div_reg, div_next;
    logic [BW-1:0]          rem_reg, rem_next;
    logic [PADW-1:0]        d_step;
    logic [BW-1:0]          r_step;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   in_neg;
    logic [CNTW-1:0]        cnt_m1;

    // digit store, least significant digit first
    logic [DW-1:0]          digit_mem [VALUE_WIDTH];
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [DW-1:0]          rd_data_reg;

    assign in_neg = q_data[VALUE_WIDTH-1];
    assign mag    = in_neg ? (~q_data + VALUE_WIDTH'(1)) : q_data;
    assign cnt_m1 = cnt_reg - CNTW'(1);

    // restoring long division by the base, STEP quotient bits per cycle
    always_comb
    begin
        logic [PADW-1:0] d;
        logic [BW-1:0]   r;
        logic [BW:0]     t;
        d = div_reg;
        r = rem_reg;
        for (int k = 0; k < STEP; k++)
        begin
            t = {r, d[PADW-1]};
            d = {d[PADW-2:0], 1'b0};
            if (t >= {1'b0, cfg.base_size})
            begin
                t    = t - {1'b0, cfg.base_size};
                d[0] = 1'b1;
            end
            r = t[BW-1:0];
        end
        d_step = d;
        r_step = r;
    end

    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        last_next  = last_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        q_pop      = 1'b0;
        out_push   = 1'b0;
        out_data   = {sibd_pkg::SYM_MINUS, 1'b0};
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = cnt_reg[AW-1:0];
        mem_raddr  = cnt_m1[AW-1:0];
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    neg_next   = in_neg;
                    div_next   = PADW'(mag);
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                div_next = d_step;
                rem_next = r_step;
                if (chunk_reg == KW'(CHUNKS - 1))
                begin
                    // one digit complete: remainder goes to the store
                    mem_we     = 1'b1;
                    cnt_next   = cnt_reg + CNTW'(1);
                    rem_next   = '0;
                    chunk_next = '0;
                    if ((d_step == '0) || (cnt_reg == CNTW'(VALUE_WIDTH - 1)))
                    begin
                        state_next = neg_reg ? B_SIGN : B_EMIT;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + KW'(1);
                end
            end
            B_SIGN:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                mem_re     = 1'b1;
                cnt_next   = cnt_m1;
                last_next  = (cnt_reg == CNTW'(1));
                state_next = B_OUT;
            end
            B_OUT:
            begin
                out_data = {cfg.alphabet[{rd_data_reg, 3'b000} +: sibd_pkg::SYM_BITS],
                            last_reg};
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = last_reg ? B_IDLE : B_EMIT;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            chunk_reg <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[mem_waddr] <= r_step[DW-1:0];
        end
        if (mem_re)
        begin
            rd_data_reg <= digit_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result written into a full queue");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < cfg.base_size))
        else $error("partial remainder not below the base");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(VALUE_WIDTH))
        else $error("digit count beyond the store depth");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && (state_reg == B_OUT) && last_reg) |=> (state_reg == B_IDLE))
        else $error("conversion continued after the final character");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (cnt_reg != '0))
        else $error("digit read with an empty store");
`endif

endmodule

// ===== rtl/signed_int_to_base_digits.sv =====
// Converts a signed VALUE_WIDTH-bit number into characters of a base of
// base_size symbols (2 to 32) taken from the four alphabet words: a '-' first
// for negatives, then the digits most significant first, last set on the
// final one; the most negative value is written with its true magnitude, and
// an invalid base (too small, too large, symbol outside 32..126, '+' or '-',
// or a repeated symbol) makes the number produce nothing. The front checks
// one alphabet symbol per cycle and can accept the next number while the
// back is still busy. The back converts with a shared long-division unit
// that takes 8 magnitude bits per cycle and stores each digit, then reads
// the digit store back one digit at a time, most significant first, and
// writes each one as a character into the result queue. The digit store
// needs no clearing after reset. Configuration must be written only while
// no conversion is in flight; the block itself does not enforce this.
module signed_int_to_base_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          full,
    input  logic                          pop,
    output logic                          empty,
    output logic [7:0]                    symbol,
    output logic                          last
);

    localparam int OW = sibd_pkg::SYM_BITS + 1;

    logic [sibd_pkg::BASE_BITS-1:0]  base_size_reg;
    logic [sibd_pkg::ALPHA_BITS-1:0] alpha_reg;
    sibd_pkg::cfg_t                  cfg;
    sibd_pkg::reg_idx_t              reg_idx;
    logic                            cfg_wr;

    logic                   q_push, q_full, q_pop, q_empty;
    logic [VALUE_WIDTH-1:0] q_wdata, q_rdata;
    logic                   out_push, out_full;
    logic [OW-1:0]          out_wdata, out_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = sibd_pkg::reg_idx_t'(paddr[5:3]);

    assign cfg.base_size = base_size_reg;
    assign cfg.alphabet  = alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg <= '0;
            alpha_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                sibd_pkg::REG_BASE_SIZE: base_size_reg <= pwdata[sibd_pkg::BASE_BITS-1:0];
                sibd_pkg::REG_ALPHA_0:   alpha_reg[0*64 +: 64] <= pwdata;
                sibd_pkg::REG_ALPHA_1:   alpha_reg[1*64 +: 64] <= pwdata;
                sibd_pkg::REG_ALPHA_2:   alpha_reg[2*64 +: 64] <= pwdata;
                sibd_pkg::REG_ALPHA_3:   alpha_reg[3*64 +: 64] <= pwdata;
                default:
                begin
                    // writes outside the register map are ignored
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sibd_pkg::REG_BASE_SIZE: prdata = 64'(base_size_reg);
            sibd_pkg::REG_ALPHA_0:   prdata = alpha_reg[0*64 +: 64];
            sibd_pkg::REG_ALPHA_1:   prdata = alpha_reg[1*64 +: 64];
            sibd_pkg::REG_ALPHA_2:   prdata = alpha_reg[2*64 +: 64];
            sibd_pkg::REG_ALPHA_3:   prdata = alpha_reg[3*64 +: 64];
            default:                 prdata = '0;
        endcase
    end

    sibd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .push   (push),
        .value  (value),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    sibd_fifo #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (sibd_pkg::QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    sibd_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_wdata)
    );

    // result queue decouples the converter from the consumer
    sibd_fifo #(
        .WIDTH (OW),
        .DEPTH (sibd_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign symbol = out_rdata[OW-1:1];
    assign last   = out_rdata[0];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_NUMBERS = 270;
    // margin for the longest conversion, plus the front and the queues
    localparam int DRAIN_CYCLES   = 300;
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } char_t;

    typedef enum int {
        FLAW_SMALL,
        FLAW_LARGE,
        FLAW_SYMBOL,
        FLAW_REPEAT
    } flaw_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [5:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic signed [31:0] value = '0;
    logic        full;
    logic        pop     = 1'b0;
    logic        empty;
    logic [7:0]  symbol;
    logic        last;

    // mirror of the register file
    logic [5:0]  cfg_base = '0;
    logic [63:0] cfg_alpha [4] = '{default: '0};

    logic [7:0]  spell [sibd_pkg::ALPHA_SLOTS] = '{default: 8'h00};
    char_t       pending_chars [$];
    char_t       head_char;
    bit          no_stalls = 1'b0;
    int          pop_hold = 0;

    int errors          = 0;
    int numbers_sent    = 0;
    int silent_numbers  = 0;
    int chars_checked   = 0;
    int settings_loaded = 0;
    int random_numbers  = 0;

    signed_int_to_base_digits #(
        .VALUE_WIDTH(32)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .value   (value),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .symbol  (symbol),
        .last    (last)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] alpha_symbol(input int idx);
        return cfg_alpha[idx / 8][(idx % 8) * 8 +: 8];
    endfunction

    function automatic bit base_valid();
        int n;
        int i;
        int j;
        logic [7:0] c;
        n = int'(cfg_base);
        if (n < 2 || n > sibd_pkg::MAX_BASE || n > sibd_pkg::ALPHA_SLOTS)
            return 1'b0;
        for (i = 0; i < n; i++)
        begin
            c = alpha_symbol(i);
            if (c < sibd_pkg::SYM_MIN || c > sibd_pkg::SYM_MAX
                || c == sibd_pkg::SYM_MINUS || c == sibd_pkg::SYM_PLUS)
                return 1'b0;
            for (j = 0; j < i; j++)
                if (alpha_symbol(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected characters for one number under the current settings
    function automatic void predict_chars(input logic [31:0] v);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [4:0]  digits [32];
        int          cnt;
        int          k;
        if (!base_valid())
        begin
            silent_numbers++;
            return;
        end
        radix = 32'(cfg_base);
        // two's complement negate also gives 2^31 for the most negative value
        mag = v[31] ? -v : v;
        cnt = 0;
        do
        begin
            digits[cnt] = 5'(mag % radix);
            mag = mag / radix;
            cnt++;
        end
        while (mag != 0 && cnt < 32);
        if (v[31])
            pending_chars.push_back('{symbol: sibd_pkg::SYM_MINUS, last: 1'b0});
        for (k = cnt - 1; k >= 0; k--)
            pending_chars.push_back('{symbol: alpha_symbol(int'(digits[k])),
                                      last: (k == 0)});
    endfunction

    // result side: random stalls on pop
    always @(posedge clk)
    begin
        if (pop_hold != 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_hold <= no_stalls ? 0 : pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected transfer: symbol %h last %b", symbol, last);
                errors++;
            end
            else
            begin
                head_char = pending_chars.pop_front();
                chars_checked++;
                if (symbol !== head_char.symbol)
                begin
                    $error("symbol: expected %h, got %h", head_char.symbol, symbol);
                    errors++;
                end
                if (last !== head_char.last)
                begin
                    $error("last: expected %b, got %b", head_char.last, last);
                    errors++;
                end
            end
        end
    end

    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = no_stalls ? 0 : pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (full !== 1'b0);
        predict_chars(v);
        numbers_sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // an invalid base leaves no results behind, so allow the block to finish
    task automatic wait_drained();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == sibd_pkg::REG_BASE_SIZE)
            cfg_base = data[5:0];
        else if (idx >= sibd_pkg::REG_ALPHA_0 && idx <= sibd_pkg::REG_ALPHA_3)
            cfg_alpha[idx - sibd_pkg::REG_ALPHA_0] = data;
    endtask

    task automatic load_alphabet(input logic [5:0] size);
        logic [63:0] word;
        logic [63:0] junk;
        int w;
        int b;
        wait_drained();
        for (w = 0; w < 4; w++)
        begin
            for (b = 0; b < 8; b++)
                word[b * 8 +: 8] = spell[w * 8 + b];
            cfg_write(3'(sibd_pkg::REG_ALPHA_0 + w), word);
        end
        // upper bits of the size word must be ignored
        junk = {$urandom, $urandom};
        junk[5:0] = size;
        cfg_write(sibd_pkg::REG_BASE_SIZE, junk);
        settings_loaded++;
    endtask

    task automatic set_spell(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            spell[i] = s[i];
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = $urandom;
        else if (r < 65)
            v = $urandom_range(0, 400) - 200;
        else if (r < 75)
            v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 3);
        else
        begin
            v = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1))
                v = -v;
        end
        return v;
    endfunction

    task automatic test_reset_base();
        // registers are zero after reset, so the base is too small
        send_value(32'd5);
        send_value(-32'sd7);
        set_spell("0");
        load_alphabet(6'd1);
        send_value(32'd3);
    endtask

    task automatic test_decimal();
        set_spell("0123456789");
        load_alphabet(6'd10);
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(-32'sd10);
    endtask

    task automatic test_binary();
        set_spell("01");
        load_alphabet(6'd2);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(-32'sd1);
    endtask

    task automatic test_widest_base();
        int i;
        int c;
        c = 32;
        for (i = 0; i < sibd_pkg::ALPHA_SLOTS - 1; i++)
        begin
            while (c == sibd_pkg::SYM_PLUS || c == sibd_pkg::SYM_MINUS)
                c++;
            spell[i] = 8'(c);
            c++;
        end
        spell[sibd_pkg::ALPHA_SLOTS - 1] = sibd_pkg::SYM_MAX;
        load_alphabet(6'(sibd_pkg::MAX_BASE));
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd31);
        send_value(32'd32);
    endtask

    task automatic test_bad_bases();
        logic [7:0] bad_codes [4];
        int i;
        bad_codes = '{8'd31, 8'd127, sibd_pkg::SYM_PLUS, sibd_pkg::SYM_MINUS};
        set_spell("0123456789");
        load_alphabet(6'd33);
        send_value(32'd77);
        load_alphabet(6'd63);
        send_value(-32'sd77);
        for (i = 0; i < 4; i++)
        begin
            set_spell("0123456789");
            spell[$urandom_range(0, 9)] = bad_codes[i];
            load_alphabet(6'd10);
            send_value(-32'sd123);
        end
        set_spell("0123456789");
        spell[9] = spell[0];
        load_alphabet(6'd10);
        send_value(32'd456);
        // slots beyond the base size are not checked
        set_spell("0123456789");
        spell[10] = 8'h00;
        spell[11] = "5";
        load_alphabet(6'd10);
        send_value(32'd99);
        wait_drained();
        cfg_write(REG_UNMAPPED, {$urandom, $urandom});
        send_value(-32'sd4096);
    endtask

    task automatic test_random();
        logic [7:0] pool [93];
        logic [7:0] t;
        int n;
        int i;
        int j;
        int count;
        int phase_items;
        bit flawed;
        flaw_t flaw;
        n = 0;
        for (i = 32; i <= 126; i++)
            if (i != sibd_pkg::SYM_PLUS && i != sibd_pkg::SYM_MINUS)
            begin
                pool[n] = 8'(i);
                n++;
            end
        while (random_numbers < RANDOM_NUMBERS)
        begin
            i = $urandom_range(0, 9);
            n = (i == 0) ? 2 : (i == 1) ? sibd_pkg::MAX_BASE
                                        : $urandom_range(3, sibd_pkg::MAX_BASE - 1);
            for (i = 0; i < sibd_pkg::ALPHA_SLOTS; i++)
            begin
                if (i < n)
                begin
                    j = $urandom_range(i, 92);
                    t = pool[i];
                    pool[i] = pool[j];
                    pool[j] = t;
                    spell[i] = pool[i];
                end
                else
                    spell[i] = 8'($urandom_range(0, 255));
            end
            flawed = ($urandom_range(0, 99) < 15);
            if (flawed)
            begin
                flaw = flaw_t'($urandom_range(0, 3));
                case (flaw)
                    FLAW_SMALL:  n = $urandom_range(0, 1);
                    FLAW_LARGE:  n = $urandom_range(sibd_pkg::MAX_BASE + 1, 63);
                    FLAW_SYMBOL:
                    begin
                        case ($urandom_range(0, 3))
                            0:       t = 8'($urandom_range(0, 31));
                            1:       t = 8'($urandom_range(127, 255));
                            2:       t = sibd_pkg::SYM_PLUS;
                            default: t = sibd_pkg::SYM_MINUS;
                        endcase
                        spell[$urandom_range(0, n - 1)] = t;
                    end
                    default:
                    begin
                        i = $urandom_range(1, n - 1);
                        spell[i] = spell[$urandom_range(0, i - 1)];
                    end
                endcase
            end
            load_alphabet(6'(n));
            no_stalls = ($urandom_range(0, 3) == 0);
            phase_items = flawed ? $urandom_range(2, 5) : $urandom_range(8, 30);
            for (count = 0; count < phase_items; count++)
            begin
                send_value(pick_value());
                if (!flawed)
                    random_numbers++;
                // hold the input back until the output side has caught up
                if (count == 4 || $urandom_range(0, 39) == 0)
                    drain_results();
            end
            no_stalls = 1'b0;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_base();
        test_decimal();
        test_binary();
        test_widest_base();
        test_bad_bases();
        test_random();
        wait_drained();
        $display("summary: %0d numbers accepted, %0d of them under an invalid base",
                 numbers_sent, silent_numbers);
        $display("summary: %0d characters checked over %0d alphabet settings",
                 chars_checked, settings_loaded);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
